// ----- hdl/cgaf_pkg.sv -----
// Package for the clamped gravity attraction force core.
// Holds the configuration register indexes; no dependencies.
`default_nettype none

package cgaf_pkg;

    localparam int CFG_IDX_BITS = 8;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_ATTRACTOR_X    = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_ATTRACTOR_Y    = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_ATTRACTOR_MASS = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_GRAVITY_CONST  = t_cfg_idx'(3);

endpackage

`default_nettype wire

// ----- hdl/clamped_gravity_attraction_force_core.sv -----
// Clamped 2D gravity attraction force core, fully pipelined.
// Depends on cgaf_pkg (register indexes).
//
// Usage: each item on the slave stream carries one particle (x, y, mass) and
// yields one item on the master stream with the force toward the attractor
// and a saturation flag in tuser. Attractor position, attractor mass and
// gravity constant sit in registers written through the cfg channel, which
// is always ready; write them only while no items are in flight.
// Throughput: one item per cycle while i_m_tready does not hold the output.
// Most of the pipeline is the bit-per-stage square root (WORD_BITS+1 stages)
// and the bit-per-stage dividers (WORD_BITS+1 stages) that run in parallel
// for both components.
// Stall: the whole pipeline holds while the output item waits for
// i_m_tready; o_s_tready is low only then, so nothing is lost or repeated.
// Reset: valid bits clear, registers return to x=0, y=0, mass=30, G=9.8.
`default_nettype none

module clamped_gravity_attraction_force_core #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire cgaf_pkg::t_cfg_idx            i_cfg_idx,
    input  wire  [WORD_BITS-1:0]               i_cfg_data,
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    // particle_x, particle_y, particle_mass (from bit 0 up), zero padded
    input  wire  [((3*WORD_BITS+7)/8)*8-1:0]   i_s_tdata,
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    // force_x, force_y (from bit 0 up), zero padded
    output logic [((2*WORD_BITS+7)/8)*8-1:0]   o_m_tdata,
    // saturated
    output logic                               o_m_tuser
);

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int DW   = W + 1;
    localparam int SW   = 2 * W + 2;
    localparam int LW   = W + 1;
    localparam int LH   = (LW + 1) / 2;
    localparam int PW   = 3 * W;
    localparam int DCW  = F + 5;
    localparam int D2W  = 2 * DCW;
    localparam int NW   = PW + DW;
    localparam int DNW  = D2W + LW;
    localparam int QB   = W + 1;
    localparam int XW   = (NW > DNW) ? NW : DNW;
    localparam int CLW  = (LW > DCW) ? LW : DCW;
    localparam int MDW  = ((2 * W + 7) / 8) * 8;
    localparam int NST  = LW + QB + 8;

    localparam logic [W-1:0]   MASS_RST = W'(30) << F;
    localparam logic [W-1:0]   GRAV_RST = W'(((98 << F) + 5) / 10);
    localparam logic [CLW-1:0] DMIN     = CLW'(5) << F;
    localparam logic [CLW-1:0] DMAX     = CLW'(25) << F;
    localparam logic [QB-1:0]  LIM_POS  = QB'((64'd1 << (W - 1)) - 64'd1);
    localparam logic [QB-1:0]  LIM_NEG  = QB'(64'd1 << (W - 1));

    logic en;

    // configuration
    logic [W-1:0] r_ax, r_ay, r_am, r_g;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= '0;
            r_ay <= '0;
            r_am <= MASS_RST;
            r_g  <= GRAV_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_idx)
                cgaf_pkg::CFG_ATTRACTOR_X:    r_ax <= i_cfg_data;
                cgaf_pkg::CFG_ATTRACTOR_Y:    r_ay <= i_cfg_data;
                cgaf_pkg::CFG_ATTRACTOR_MASS: r_am <= i_cfg_data;
                cgaf_pkg::CFG_GRAVITY_CONST:  r_g  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits
    logic [NST-1:0] r_vld;

    assign en         = !r_vld[NST-1] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_s_tvalid};
        end
    end

    // stage 1: differences, magnitudes, G*M
    logic signed [DW-1:0] w_dx, w_dy;
    logic [DW-1:0]  r_s1_mx, r_s1_my;
    logic           r_s1_nx, r_s1_ny, r_s1_zero;
    logic [W-1:0]   r_s1_m;
    logic [2*W-1:0] r_s1_gm;

    assign w_dx = DW'($signed(r_ax)) - DW'($signed(i_s_tdata[W-1:0]));
    assign w_dy = DW'($signed(r_ay)) - DW'($signed(i_s_tdata[2*W-1:W]));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_mx   <= w_dx[DW-1] ? DW'(-w_dx) : DW'(w_dx);
            r_s1_my   <= w_dy[DW-1] ? DW'(-w_dy) : DW'(w_dy);
            r_s1_nx   <= w_dx[DW-1];
            r_s1_ny   <= w_dy[DW-1];
            r_s1_zero <= (w_dx == '0) && (w_dy == '0);
            r_s1_m    <= i_s_tdata[3*W-1:2*W];
            r_s1_gm   <= r_g * r_am;
        end
    end

    // stage 2: squares, partial products of G*M*m
    logic [2*DW-1:0] r_s2_sx, r_s2_sy;
    logic [2*W-1:0]  r_s2_plo, r_s2_phi;
    logic [DW-1:0]   r_s2_mx, r_s2_my;
    logic            r_s2_nx, r_s2_ny, r_s2_zero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_sx   <= r_s1_mx * r_s1_mx;
            r_s2_sy   <= r_s1_my * r_s1_my;
            r_s2_plo  <= r_s1_gm[W-1:0] * r_s1_m;
            r_s2_phi  <= r_s1_gm[2*W-1:W] * r_s1_m;
            r_s2_mx   <= r_s1_mx;
            r_s2_my   <= r_s1_my;
            r_s2_nx   <= r_s1_nx;
            r_s2_ny   <= r_s1_ny;
            r_s2_zero <= r_s1_zero;
        end
    end

    // square root, one result bit per stage; index 0 is the entry
    logic [SW-1:0] r_sq_rem  [0:LW];
    logic [LW-1:0] r_sq_root [0:LW];
    logic [PW-1:0] r_sq_p    [0:LW];
    logic [DW-1:0] r_sq_mx   [0:LW];
    logic [DW-1:0] r_sq_my   [0:LW];
    logic [LW:0]   r_sq_nx, r_sq_ny, r_sq_zero;
    logic [SW-1:0] n_sq_rem  [1:LW];
    logic [LW-1:0] n_sq_root [1:LW];

    always_comb begin
        logic [SW-1:0] w_tr;
        int b;
        for (int k = 0; k < LW; k++) begin
            b    = LW - 1 - k;
            w_tr = (SW'(r_sq_root[k]) << (b + 1)) | (SW'(1) << (2 * b));
            if (r_sq_rem[k] >= w_tr) begin
                n_sq_rem[k+1]  = r_sq_rem[k] - w_tr;
                n_sq_root[k+1] = r_sq_root[k] | (LW'(1) << b);
            end else begin
                n_sq_rem[k+1]  = r_sq_rem[k];
                n_sq_root[k+1] = r_sq_root[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_rem[0]  <= SW'(r_s2_sx) + SW'(r_s2_sy);
            r_sq_root[0] <= '0;
            r_sq_p[0]    <= PW'(r_s2_plo) + (PW'(r_s2_phi) << W);
            r_sq_mx[0]   <= r_s2_mx;
            r_sq_my[0]   <= r_s2_my;
            r_sq_nx[0]   <= r_s2_nx;
            r_sq_ny[0]   <= r_s2_ny;
            r_sq_zero[0] <= r_s2_zero;
            for (int k = 0; k < LW; k++) begin
                r_sq_rem[k+1]  <= n_sq_rem[k+1];
                r_sq_root[k+1] <= n_sq_root[k+1];
                r_sq_p[k+1]    <= r_sq_p[k];
                r_sq_mx[k+1]   <= r_sq_mx[k];
                r_sq_my[k+1]   <= r_sq_my[k];
                r_sq_nx[k+1]   <= r_sq_nx[k];
                r_sq_ny[k+1]   <= r_sq_ny[k];
                r_sq_zero[k+1] <= r_sq_zero[k];
            end
        end
    end

    // c1: clamp distance
    logic [CLW-1:0] w_len;
    logic [DCW-1:0] r_c1_dc;
    logic [LW-1:0]  r_c1_len;
    logic [PW-1:0]  r_c1_p;
    logic [DW-1:0]  r_c1_mx, r_c1_my;
    logic           r_c1_nx, r_c1_ny, r_c1_zero;

    assign w_len = CLW'(r_sq_root[LW]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (w_len < DMIN) begin
                r_c1_dc <= DCW'(DMIN);
            end else if (w_len > DMAX) begin
                r_c1_dc <= DCW'(DMAX);
            end else begin
                r_c1_dc <= DCW'(w_len);
            end
            r_c1_len  <= r_sq_root[LW];
            r_c1_p    <= r_sq_p[LW];
            r_c1_mx   <= r_sq_mx[LW];
            r_c1_my   <= r_sq_my[LW];
            r_c1_nx   <= r_sq_nx[LW];
            r_c1_ny   <= r_sq_ny[LW];
            r_c1_zero <= r_sq_zero[LW];
        end
    end

    // c2: dc squared, numerator partial products
    logic [D2W-1:0]    r_c2_dc2;
    logic [W+DW-1:0]   r_c2_ppx [0:2];
    logic [W+DW-1:0]   r_c2_ppy [0:2];
    logic [LW-1:0]     r_c2_len;
    logic              r_c2_nx, r_c2_ny, r_c2_zero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c2_dc2 <= r_c1_dc * r_c1_dc;
            for (int j = 0; j < 3; j++) begin
                r_c2_ppx[j] <= r_c1_p[j*W +: W] * r_c1_mx;
                r_c2_ppy[j] <= r_c1_p[j*W +: W] * r_c1_my;
            end
            r_c2_len  <= r_c1_len;
            r_c2_nx   <= r_c1_nx;
            r_c2_ny   <= r_c1_ny;
            r_c2_zero <= r_c1_zero;
        end
    end

    // c3: numerators, denominator partial products
    logic [NW-1:0]         r_c3_numx, r_c3_numy;
    logic [D2W+LH-1:0]     r_c3_dl;
    logic [D2W+LW-LH-1:0]  r_c3_dh;
    logic                  r_c3_nx, r_c3_ny, r_c3_zero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c3_numx <= NW'(r_c2_ppx[0]) + (NW'(r_c2_ppx[1]) << W)
                       + (NW'(r_c2_ppx[2]) << (2 * W));
            r_c3_numy <= NW'(r_c2_ppy[0]) + (NW'(r_c2_ppy[1]) << W)
                       + (NW'(r_c2_ppy[2]) << (2 * W));
            r_c3_dl   <= r_c2_dc2 * r_c2_len[LH-1:0];
            r_c3_dh   <= r_c2_dc2 * r_c2_len[LW-1:LH];
            r_c3_nx   <= r_c2_nx;
            r_c3_ny   <= r_c2_ny;
            r_c3_zero <= r_c2_zero;
        end
    end

    // dividers for both components, one quotient bit per stage
    logic [DNW-1:0] w_den;
    logic [NW-1:0]  r_dv_rem [0:1][0:QB];
    logic [QB-1:0]  r_dv_q   [0:1][0:QB];
    logic [QB:0]    r_dv_ovf [0:1];
    logic [QB:0]    r_dv_neg [0:1];
    logic [DNW-1:0] r_dv_den [0:QB];
    logic [QB:0]    r_dv_zero;
    logic [NW-1:0]  n_dv_rem [0:1][1:QB];
    logic [QB-1:0]  n_dv_q   [0:1][1:QB];

    assign w_den = DNW'(r_c3_dl) + (DNW'(r_c3_dh) << LH);

    always_comb begin
        logic [XW-1:0] w_hi;
        int b;
        for (int c = 0; c < 2; c++) begin
            for (int k = 0; k < QB; k++) begin
                b    = QB - 1 - k;
                w_hi = XW'(r_dv_rem[c][k] >> b);
                if (w_hi >= XW'(r_dv_den[k])) begin
                    n_dv_rem[c][k+1] = r_dv_rem[c][k] - (NW'(r_dv_den[k]) << b);
                    n_dv_q[c][k+1]   = r_dv_q[c][k] | (QB'(1) << b);
                end else begin
                    n_dv_rem[c][k+1] = r_dv_rem[c][k];
                    n_dv_q[c][k+1]   = r_dv_q[c][k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_rem[0][0] <= r_c3_numx;
            r_dv_rem[1][0] <= r_c3_numy;
            r_dv_q[0][0]   <= '0;
            r_dv_q[1][0]   <= '0;
            r_dv_ovf[0][0] <= XW'(r_c3_numx >> QB) >= XW'(w_den);
            r_dv_ovf[1][0] <= XW'(r_c3_numy >> QB) >= XW'(w_den);
            r_dv_neg[0][0] <= r_c3_nx;
            r_dv_neg[1][0] <= r_c3_ny;
            r_dv_den[0]    <= w_den;
            r_dv_zero[0]   <= r_c3_zero;
            for (int k = 0; k < QB; k++) begin
                for (int c = 0; c < 2; c++) begin
                    r_dv_rem[c][k+1] <= n_dv_rem[c][k+1];
                    r_dv_q[c][k+1]   <= n_dv_q[c][k+1];
                    r_dv_ovf[c][k+1] <= r_dv_ovf[c][k];
                    r_dv_neg[c][k+1] <= r_dv_neg[c][k];
                end
                r_dv_den[k+1]  <= r_dv_den[k];
                r_dv_zero[k+1] <= r_dv_zero[k];
            end
        end
    end

    // output: saturate, apply sign
    logic [W-1:0]  w_f   [0:1];
    logic [1:0]    w_sat;
    logic [W-1:0]  r_fx, r_fy;
    logic          r_sat;

    always_comb begin
        logic [QB-1:0] w_lim;
        logic [W-1:0]  w_mag;
        for (int c = 0; c < 2; c++) begin
            w_lim    = r_dv_neg[c][QB] ? LIM_NEG : LIM_POS;
            w_sat[c] = r_dv_ovf[c][QB] || (r_dv_q[c][QB] > w_lim);
            w_mag    = w_sat[c] ? W'(w_lim) : W'(r_dv_q[c][QB]);
            if (r_dv_zero[QB]) begin
                w_f[c] = '0;
            end else if (r_dv_neg[c][QB]) begin
                w_f[c] = W'(~w_mag + W'(1));
            end else begin
                w_f[c] = w_mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fx  <= w_f[0];
            r_fy  <= w_f[1];
            r_sat <= !r_dv_zero[QB] && (w_sat != 2'b00);
        end
    end

    assign o_m_tdata = MDW'({r_fy, r_fx});
    assign o_m_tuser = r_sat;

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for clamped_gravity_attraction_force_core.
// Drives particles and register writes with random idling on both streams and
// checks every force item against an exact wide-integer prediction.
// Depends on cgaf_pkg and the core.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = 32;
    localparam logic [W-1:0] MAXPOS = 32'h7fff_ffff;
    localparam logic [W-1:0] MAXNEG = 32'h8000_0000;
    localparam logic [W-1:0] ONE = 32'h0001_0000;

    typedef struct packed {
        logic [W-1:0] fx;
        logic [W-1:0] fy;
        logic         sat;
    } t_force;

    class force_board;
        logic [W-1:0] ax, ay, am, gc;
        t_force       due[$];
        int           errors;

        function new();
            ax = '0;
            ay = '0;
            am = 32'd1966080;
            gc = 32'd642253;
            errors = 0;
        endfunction

        function void set_reg(cgaf_pkg::t_cfg_idx idx, logic [W-1:0] v);
            case (idx)
                cgaf_pkg::CFG_ATTRACTOR_X:    ax = v;
                cgaf_pkg::CFG_ATTRACTOR_Y:    ay = v;
                cgaf_pkg::CFG_ATTRACTOR_MASS: am = v;
                cgaf_pkg::CFG_GRAVITY_CONST:  gc = v;
                default: ;
            endcase
        endfunction

        function logic [W-1:0] pull(logic [255:0] mag, bit neg, logic [255:0] prod,
                                    logic [255:0] dc2, logic [255:0] len, ref bit sat);
            logic [255:0] q;
            logic [255:0] lim;
            q = prod * mag / dc2 / len;
            lim = neg ? 256'(MAXNEG) : 256'(MAXPOS);
            if (q > lim) begin
                q = lim;
                sat = 1'b1;
            end
            return neg ? W'(-q[W-1:0]) : q[W-1:0];
        endfunction

        function void note(logic [W-1:0] px, logic [W-1:0] py, logic [W-1:0] pm);
            longint       dx, dy;
            logic [255:0] mx, my, s, r, c, dc, prod;
            bit           sat;
            t_force       f;
            dx = longint'($signed(ax)) - longint'($signed(px));
            dy = longint'($signed(ay)) - longint'($signed(py));
            mx = dx < 0 ? 256'(-dx) : 256'(dx);
            my = dy < 0 ? 256'(-dy) : 256'(dy);
            sat = 1'b0;
            if (mx == 0 && my == 0) begin
                f = '0;
            end else begin
                s = mx * mx + my * my;
                r = '0;
                for (int b = 40; b >= 0; b--) begin
                    c = r | (256'(1) << b);
                    if (c * c <= s) r = c;
                end
                dc = r < 256'(5 << 16) ? 256'(5 << 16) :
                     (r > 256'(25 << 16) ? 256'(25 << 16) : r);
                prod = 256'(gc) * 256'(am) * 256'(pm);
                f.fx = pull(mx, dx < 0, prod, dc * dc, r, sat);
                f.fy = pull(my, dy < 0, prod, dc * dc, r, sat);
                f.sat = sat;
            end
            due.push_back(f);
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check(logic [W-1:0] fx, logic [W-1:0] fy, logic sat);
            t_force f;
            if (due.size() == 0) begin
                report($sformatf("unexpected item fx=%h fy=%h", fx, fy));
                return;
            end
            f = due.pop_front();
            if (fx !== f.fx) report($sformatf("force_x %h, want %h", fx, f.fx));
            if (fy !== f.fy) report($sformatf("force_y %h, want %h", fy, f.fy));
            if (sat !== f.sat) report($sformatf("saturated %b, want %b", sat, f.sat));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    cgaf_pkg::t_cfg_idx i_cfg_idx;
    logic [W-1:0]       i_cfg_data;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [95:0]        i_s_tdata;
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [63:0]        o_m_tdata;
    logic               o_m_tuser;

    force_board board;
    bit         calm;

    clamped_gravity_attraction_force_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check(o_m_tdata[31:0], o_m_tdata[63:32], o_m_tuser);
    end

    always @(negedge i_clk) begin
        i_m_tready = calm || ($urandom_range(99) >= 24);
    end

    task automatic write_reg(cgaf_pkg::t_cfg_idx idx, logic [W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, v);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain();
        while (board.due.size() != 0) @(posedge i_clk);
        repeat (90) @(posedge i_clk);
    endtask

    task automatic send(logic [W-1:0] px, logic [W-1:0] py, logic [W-1:0] pm);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 24) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata = {pm, py, px};
        do @(posedge i_clk); while (!o_s_tready);
        board.note(px, py, pm);
    endtask

    task automatic send_near(int span);
        logic [W-1:0] px, py;
        px = board.ax + W'($signed($urandom_range(2 * span, 0)) - span) * 32'(ONE)
             + $urandom_range(65535);
        py = board.ay + W'($signed($urandom_range(2 * span, 0)) - span) * 32'(ONE)
             + $urandom_range(65535);
        send(px, py, $urandom_range(3) == 0 ? $urandom() : $urandom_range(100 << 16));
    endtask

    task automatic random_phase(int n);
        for (int k = 0; k < n; k++) begin
            calm = (k >= n / 3 && k < n / 3 + 60);
            case ($urandom_range(3))
                0: send($urandom(), $urandom(), $urandom());
                1: send_near(4);
                default: send_near(40);
            endcase
        end
        calm = 1'b0;
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        drain();
    endtask

    initial begin
        board = new();
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_idx = cgaf_pkg::CFG_ATTRACTOR_X;
        i_cfg_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values: zero length, short and long range, extremes
        send(32'd0, 32'd0, ONE);
        send(ONE, 32'd0, ONE);
        send(32'd0, 32'd3 << 16, ONE);
        send(32'd100 << 16, 32'd100 << 16, ONE);
        send(MAXPOS, MAXNEG, 32'hffff_ffff);
        send(MAXNEG, MAXPOS, 32'd0);
        send(32'd1, 32'd0, 32'hffff_ffff);
        send(32'hffff_ffff, 32'hffff_ffff, 32'd10 << 16);
        send(32'd25 << 16, 32'd0, 32'd5 << 16);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        drain();

        write_reg(cgaf_pkg::CFG_ATTRACTOR_X, MAXPOS);
        write_reg(cgaf_pkg::CFG_ATTRACTOR_Y, MAXNEG);
        write_reg(cgaf_pkg::CFG_ATTRACTOR_MASS, 32'hffff_ffff);
        write_reg(cgaf_pkg::CFG_GRAVITY_CONST, 32'hffff_ffff);
        write_reg(cgaf_pkg::t_cfg_idx'(7), 32'h1234_5678);
        send(MAXNEG, MAXPOS, 32'hffff_ffff);
        send(MAXPOS, MAXNEG, ONE);
        send(MAXPOS - 32'd1, MAXNEG, 32'hffff_ffff);
        send(MAXPOS, MAXNEG + (32'd30 << 16), 32'd1);
        send(32'd0, 32'd0, 32'd0);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        drain();
        random_phase(200);

        write_reg(cgaf_pkg::CFG_ATTRACTOR_X, MAXNEG);
        write_reg(cgaf_pkg::CFG_ATTRACTOR_Y, MAXPOS);
        write_reg(cgaf_pkg::CFG_ATTRACTOR_MASS, 32'd0);
        write_reg(cgaf_pkg::CFG_GRAVITY_CONST, 32'd0);
        random_phase(120);

        write_reg(cgaf_pkg::CFG_ATTRACTOR_X, 32'd0);
        write_reg(cgaf_pkg::CFG_ATTRACTOR_Y, 32'd0);
        write_reg(cgaf_pkg::CFG_ATTRACTOR_MASS, 32'd1966080);
        write_reg(cgaf_pkg::CFG_GRAVITY_CONST, 32'd642253);
        random_phase(300);

        for (int p = 0; p < 4; p++) begin
            write_reg(cgaf_pkg::CFG_ATTRACTOR_X, $urandom());
            write_reg(cgaf_pkg::CFG_ATTRACTOR_Y, $urandom());
            write_reg(cgaf_pkg::CFG_ATTRACTOR_MASS, $urandom_range(1000 << 16));
            write_reg(cgaf_pkg::CFG_GRAVITY_CONST,
                      p == 3 ? $urandom() : $urandom_range(20 << 16));
            random_phase(130);
        end

        if (board.errors == 0 && board.due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
hdl/cgaf_pkg.sv
hdl/clamped_gravity_attraction_force_core.sv
tb/sv/testbench.sv
